FILE: design/iecq_pkg.sv
`default_nettype none

package iecq_pkg;

  // Queue geometry
  localparam int QueueDepth = 16;
  localparam int IdxW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW       = $clog2(QueueDepth + 1);

  // Result status codes
  typedef enum logic [2:0] {
    StAppend = 3'd0,
    StMerge  = 3'd1,
    StDrop   = 3'd2,
    StPop    = 3'd3,
    StEmpty  = 3'd4
  } status_e;

  // Operation and event kind codes
  localparam logic FuncPush  = 1'b0;
  localparam logic FuncPop   = 1'b1;
  localparam logic EvButton  = 1'b0;
  localparam logic EvEncoder = 1'b1;

  // Button states that take part in the double-click merge
  localparam logic [2:0] CodeClick  = 3'd3;
  localparam logic [2:0] CodeDouble = 3'd5;

  // Core entry: kind, id, code and step counters (39 bits)
  typedef struct packed {
    logic [15:0] abs_steps;
    logic [15:0] steps;
    logic [2:0]  code;
    logic [2:0]  dev_id;
    logic        ev_type;
  } core_t;

  // Payload entry: carried unchanged (32 bits)
  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] position;
  } payload_t;

  // Merge decision handed back to the controller
  typedef struct packed {
    logic  hit;
    core_t entry;
  } merge_t;

  localparam int CoreW    = $bits(core_t);
  localparam int PayloadW = $bits(payload_t);

endpackage

`default_nettype wire

FILE: design/input_event_queue_coalesce.sv
`default_nettype none

// Input event queue with coalescing of button and encoder events.
//
// Command channel: a beat is taken at a rising edge with start_i high and
// busy_o low. func_i selects push (0) or pop (1); the event fields ride
// along. Each beat produces exactly one result beat, shown on the out_*
// ports, status_o and queue_length_o for one cycle with done_o high.
//
// A beat taken at an edge is worked in the following cycle (busy_o high)
// and its result is registered and shown in the cycle after that. A new
// beat may be taken at the edge that ends the result cycle, so a beat is
// not taken before the last one is through. This is set by the registered
// read of the entry memories followed by the write-back of the merged or
// appended entry.
//
// Reset empties the queue (head, tail and count cleared); entry memories are
// not cleared since only held entries are ever read. The receiver cannot
// stall: each result is taken in the cycle it is shown.

module input_event_queue_coalesce (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        func_i,
  input  wire logic        ev_type_i,
  input  wire logic [2:0]  dev_id_i,
  input  wire logic [2:0]  code_i,
  input  wire logic [15:0] steps_i,
  input  wire logic [15:0] abs_steps_i,
  input  wire logic signed [15:0] position_i,
  input  wire logic [15:0] speed_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic             out_type_o,
  output logic [2:0]       out_id_o,
  output logic [2:0]       out_code_o,
  output logic [15:0]      out_steps_o,
  output logic [15:0]      out_abs_steps_o,
  output logic signed [15:0] out_position_o,
  output logic [15:0]      out_speed_o,
  output logic [4:0]       queue_length_o
);

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  localparam int IdxW = iecq_pkg::IdxW;
  localparam int CntW = iecq_pkg::CntW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(iecq_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(iecq_pkg::QueueDepth);

  state_e               state_q;
  logic [IdxW-1:0]      head_q, head_d;
  logic [IdxW-1:0]      tail_q, tail_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [IdxW-1:0]      last_q;
  logic                 func_q;
  iecq_pkg::core_t      event_q;
  iecq_pkg::payload_t   evpay_q;

  logic                 accept;
  logic [IdxW-1:0]      tail_prev;
  logic [IdxW-1:0]      raddr;
  logic                 core_we;
  logic [IdxW-1:0]      core_waddr;
  iecq_pkg::core_t      core_wdata;
  logic                 pay_we;
  iecq_pkg::core_t      core_rdata;
  iecq_pkg::payload_t   pay_rdata;
  iecq_pkg::merge_t     merge;
  logic                 nonempty;
  logic                 full;
  iecq_pkg::status_e    status_d;
  iecq_pkg::core_t      res_core_d;
  iecq_pkg::payload_t   res_pay_d;

  assign accept    = start_i && !busy_o;
  assign busy_o    = (state_q == StExec);
  assign nonempty  = (count_q != '0);
  assign full      = (count_q >= FullCnt);
  assign tail_prev = (tail_q == '0) ? LastIdx : (tail_q - IdxW'(1));

  // Read the tail entry on push, the head entry on pop
  assign raddr = (func_i == iecq_pkg::FuncPop) ? head_q : tail_prev;

  iecq_ram #(
    .Width(iecq_pkg::CoreW),
    .Depth(iecq_pkg::QueueDepth)
  ) u_core_ram (
    .clk_i   (clk_i),
    .we_i    (core_we),
    .waddr_i (core_waddr),
    .wdata_i (core_wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (core_rdata)
  );

  iecq_ram #(
    .Width(iecq_pkg::PayloadW),
    .Depth(iecq_pkg::QueueDepth)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (tail_q),
    .wdata_i (evpay_q),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (pay_rdata)
  );

  iecq_merge u_merge (
    .valid_i (nonempty),
    .tail_i  (core_rdata),
    .event_i (event_q),
    .merge_o (merge)
  );

  // Decide the outcome and the write-back for the item in flight
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    core_we    = 1'b0;
    core_waddr = tail_q;
    core_wdata = event_q;
    pay_we     = 1'b0;
    res_core_d = '0;
    res_pay_d  = '0;
    status_d   = iecq_pkg::StEmpty;
    if (state_q == StExec) begin
      if (func_q == iecq_pkg::FuncPush) begin
        if (merge.hit) begin
          status_d   = iecq_pkg::StMerge;
          core_we    = 1'b1;
          core_waddr = last_q;
          core_wdata = merge.entry;
        end else if (full) begin
          status_d = iecq_pkg::StDrop;
        end else begin
          status_d = iecq_pkg::StAppend;
          core_we  = 1'b1;
          pay_we   = 1'b1;
          tail_d   = (tail_q == LastIdx) ? '0 : (tail_q + IdxW'(1));
          count_d  = count_q + CntW'(1);
        end
      end else if (nonempty) begin
        status_d   = iecq_pkg::StPop;
        res_core_d = core_rdata;
        res_pay_d  = pay_rdata;
        head_d     = (head_q == LastIdx) ? '0 : (head_q + IdxW'(1));
        count_d    = count_q - CntW'(1);
      end
    end
  end

  // Hold the accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q            <= func_i;
      last_q            <= tail_prev;
      event_q.ev_type   <= ev_type_i;
      event_q.dev_id    <= dev_id_i;
      event_q.code      <= code_i;
      event_q.steps     <= steps_i;
      event_q.abs_steps <= abs_steps_i;
      evpay_q.position  <= position_i;
      evpay_q.speed     <= speed_i;
    end
  end

  // Advance state, queue pointers and the registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      head_q          <= '0;
      tail_q          <= '0;
      count_q         <= '0;
      done_o          <= 1'b0;
      status_o        <= '0;
      out_type_o      <= 1'b0;
      out_id_o        <= '0;
      out_code_o      <= '0;
      out_steps_o     <= '0;
      out_abs_steps_o <= '0;
      out_position_o  <= '0;
      out_speed_o     <= '0;
      queue_length_o  <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          state_q         <= StIdle;
          head_q          <= head_d;
          tail_q          <= tail_d;
          count_q         <= count_d;
          done_o          <= 1'b1;
          status_o        <= status_d;
          out_type_o      <= res_core_d.ev_type;
          out_id_o        <= res_core_d.dev_id;
          out_code_o      <= res_core_d.code;
          out_steps_o     <= res_core_d.steps;
          out_abs_steps_o <= res_core_d.abs_steps;
          out_position_o  <= res_pay_d.position;
          out_speed_o     <= res_pay_d.speed;
          queue_length_o  <= 5'(count_d);
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("entry count above queue depth");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o && !done_o))
    else $error("accepted beat not worked in the next cycle");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == iecq_pkg::StPop)) |-> (count_q == ($past(count_q) - CntW'(1))))
    else $error("pop did not reduce the count by one");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == iecq_pkg::StDrop)) |-> (count_q == FullCnt))
    else $error("event dropped while queue not full");

  a_merge_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == iecq_pkg::StMerge)) |-> (count_q != '0))
    else $error("merge reported on an empty queue");

endmodule

`default_nettype wire

FILE: design/iecq_ram.sv
`default_nettype none

module iecq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/iecq_merge.sv
`default_nettype none

module iecq_merge (
  input  wire logic           valid_i,
  input  wire iecq_pkg::core_t tail_i,
  input  wire iecq_pkg::core_t event_i,
  output iecq_pkg::merge_t    merge_o
);

  logic enc_hit;
  logic btn_hit;

  // Match encoder events on id and direction, button double-click on a tail click
  assign enc_hit = (event_i.ev_type == iecq_pkg::EvEncoder) &&
                   (tail_i.ev_type == iecq_pkg::EvEncoder) &&
                   (tail_i.code == event_i.code) && (tail_i.dev_id == event_i.dev_id);
  assign btn_hit = (event_i.ev_type == iecq_pkg::EvButton) &&
                   (tail_i.ev_type == iecq_pkg::EvButton) &&
                   (tail_i.dev_id == event_i.dev_id) &&
                   (tail_i.code == iecq_pkg::CodeClick) &&
                   (event_i.code == iecq_pkg::CodeDouble);

  // Build the updated tail entry
  always_comb begin
    merge_o.hit   = valid_i && (enc_hit || btn_hit);
    merge_o.entry = tail_i;
    if (enc_hit) begin
      merge_o.entry.steps     = tail_i.steps + 16'd1;
      merge_o.entry.abs_steps = tail_i.abs_steps + event_i.abs_steps;
    end else if (btn_hit) begin
      merge_o.entry.code = iecq_pkg::CodeDouble;
    end
  end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Shadow of the event queue: predicts one result per command beat and checks it
class coalesce_checker;

  typedef struct {
    iecq_pkg::status_e status;
    logic              ev_type;
    logic [2:0]        dev_id;
    logic [2:0]        code;
    logic [15:0]       steps;
    logic [15:0]       abs_steps;
    logic signed [15:0] position;
    logic [15:0]       speed;
    logic [4:0]        qlen;
  } queue_result_t;

  iecq_pkg::core_t    shadow_core[iecq_pkg::QueueDepth];
  iecq_pkg::payload_t shadow_payload[iecq_pkg::QueueDepth];
  int head_slot;
  int tail_slot;
  int held;
  queue_result_t expected_results[$];
  int errors;

  function new();
    head_slot = 0;
    tail_slot = 0;
    held      = 0;
    errors    = 0;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  task report(input string msg);
    if (errors < 40) $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  // Work out the result of one accepted beat and advance the shadow queue
  function void note_beat(input logic func, input logic ev_type, input logic [2:0] dev_id,
                          input logic [2:0] code, input logic [15:0] steps,
                          input logic [15:0] abs_steps, input logic signed [15:0] position,
                          input logic [15:0] speed);
    queue_result_t   res;
    iecq_pkg::core_t tail_entry;
    int              last;
    bit              merged;
    res = '{status: iecq_pkg::StAppend, ev_type: 1'b0, dev_id: '0, code: '0, steps: '0,
            abs_steps: '0, position: '0, speed: '0, qlen: '0};
    merged = 1'b0;
    if (func == iecq_pkg::FuncPush) begin
      // Try to fold the event into the newest entry
      if (held != 0) begin
        last = (tail_slot == 0) ? iecq_pkg::QueueDepth - 1 : tail_slot - 1;
        tail_entry = shadow_core[last];
        if (ev_type == iecq_pkg::EvEncoder && tail_entry.ev_type == iecq_pkg::EvEncoder) begin
          if (tail_entry.code == code && tail_entry.dev_id == dev_id) begin
            tail_entry.steps     = tail_entry.steps + 16'd1;
            tail_entry.abs_steps = tail_entry.abs_steps + abs_steps;
            merged = 1'b1;
          end
        end else if (ev_type == iecq_pkg::EvButton && tail_entry.ev_type == iecq_pkg::EvButton) begin
          if (tail_entry.dev_id == dev_id && tail_entry.code == iecq_pkg::CodeClick &&
              code == iecq_pkg::CodeDouble) begin
            tail_entry.code = iecq_pkg::CodeDouble;
            merged = 1'b1;
          end
        end
        if (merged) shadow_core[last] = tail_entry;
      end
      if (merged) begin
        res.status = iecq_pkg::StMerge;
      end else if (held >= iecq_pkg::QueueDepth) begin
        res.status = iecq_pkg::StDrop;
      end else begin
        shadow_core[tail_slot] = '{abs_steps: abs_steps, steps: steps, code: code,
                                   dev_id: dev_id, ev_type: ev_type};
        shadow_payload[tail_slot] = '{speed: speed, position: position};
        tail_slot = (tail_slot + 1 >= iecq_pkg::QueueDepth) ? 0 : tail_slot + 1;
        held++;
        res.status = iecq_pkg::StAppend;
      end
    end else begin
      // Hand back the oldest entry
      if (held == 0) begin
        res.status = iecq_pkg::StEmpty;
      end else begin
        res.ev_type   = shadow_core[head_slot].ev_type;
        res.dev_id    = shadow_core[head_slot].dev_id;
        res.code      = shadow_core[head_slot].code;
        res.steps     = shadow_core[head_slot].steps;
        res.abs_steps = shadow_core[head_slot].abs_steps;
        res.position  = shadow_payload[head_slot].position;
        res.speed     = shadow_payload[head_slot].speed;
        head_slot = (head_slot + 1 >= iecq_pkg::QueueDepth) ? 0 : head_slot + 1;
        held--;
        res.status = iecq_pkg::StPop;
      end
    end
    res.qlen = held[4:0];
    expected_results.push_back(res);
  endfunction

  task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  // Compare one result beat with the oldest expectation
  task check_result(input queue_result_t got);
    queue_result_t want;
    if (expected_results.size() == 0) begin
      report("result beat with nothing expected");
    end else begin
      want = expected_results.pop_front();
      compare_field("status", 16'(got.status), 16'(want.status));
      compare_field("out_type", 16'(got.ev_type), 16'(want.ev_type));
      compare_field("out_id", 16'(got.dev_id), 16'(want.dev_id));
      compare_field("out_code", 16'(got.code), 16'(want.code));
      compare_field("out_steps", got.steps, want.steps);
      compare_field("out_abs_steps", got.abs_steps, want.abs_steps);
      compare_field("out_position", got.position, want.position);
      compare_field("out_speed", got.speed, want.speed);
      compare_field("queue_length", 16'(got.qlen), 16'(want.qlen));
    end
  endtask

endclass

module testbench;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               func_i = iecq_pkg::FuncPush;
  logic               ev_type_i = iecq_pkg::EvButton;
  logic [2:0]         dev_id_i = '0;
  logic [2:0]         code_i = '0;
  logic [15:0]        steps_i = '0;
  logic [15:0]        abs_steps_i = '0;
  logic signed [15:0] position_i = '0;
  logic [15:0]        speed_i = '0;
  logic               done_o;
  logic [2:0]         status_o;
  logic               out_type_o;
  logic [2:0]         out_id_o;
  logic [2:0]         out_code_o;
  logic [15:0]        out_steps_o;
  logic [15:0]        out_abs_steps_o;
  logic signed [15:0] out_position_o;
  logic [15:0]        out_speed_o;
  logic [4:0]         queue_length_o;

  coalesce_checker sb = new();
  int burst_left = 0;
  logic       last_type = iecq_pkg::EvEncoder;
  logic [2:0] last_id = '0;
  logic [2:0] last_code = '0;

  input_event_queue_coalesce DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .ev_type_i       (ev_type_i),
    .dev_id_i        (dev_id_i),
    .code_i          (code_i),
    .steps_i         (steps_i),
    .abs_steps_i     (abs_steps_i),
    .position_i      (position_i),
    .speed_i         (speed_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .out_type_o      (out_type_o),
    .out_id_o        (out_id_o),
    .out_code_o      (out_code_o),
    .out_steps_o     (out_steps_o),
    .out_abs_steps_o (out_abs_steps_o),
    .out_position_o  (out_position_o),
    .out_speed_o     (out_speed_o),
    .queue_length_o  (queue_length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check result beats, then note the command beat taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_result('{status: iecq_pkg::status_e'(status_o), ev_type: out_type_o,
                          dev_id: out_id_o, code: out_code_o, steps: out_steps_o,
                          abs_steps: out_abs_steps_o, position: out_position_o,
                          speed: out_speed_o, qlen: queue_length_o});
      end
      if (start_i && !busy_o) begin
        sb.note_beat(func_i, ev_type_i, dev_id_i, code_i, steps_i, abs_steps_i,
                     position_i, speed_i);
      end
    end
  end

  // Fill the command fields with noise while no beat is offered
  task automatic scramble_fields();
    func_i      = 1'($urandom_range(0, 1));
    ev_type_i   = 1'($urandom_range(0, 1));
    dev_id_i    = 3'($urandom_range(0, 7));
    code_i      = 3'($urandom_range(0, 7));
    steps_i     = 16'($urandom_range(0, 65535));
    abs_steps_i = 16'($urandom_range(0, 65535));
    position_i  = 16'($urandom_range(0, 65535));
    speed_i     = 16'($urandom_range(0, 65535));
  endtask

  // Offer one beat, with a random gap at the end of each burst
  task automatic send_beat(input logic func, input logic ev_type, input logic [2:0] dev_id,
                           input logic [2:0] code, input logic [15:0] steps,
                           input logic [15:0] abs_steps, input logic signed [15:0] position,
                           input logic [15:0] speed);
    int gap;
    bit taken;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk_i);
        start_i = 1'b0;
        scramble_fields();
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    start_i     = 1'b1;
    func_i      = func;
    ev_type_i   = ev_type;
    dev_id_i    = dev_id;
    code_i      = code;
    steps_i     = steps;
    abs_steps_i = abs_steps;
    position_i  = position;
    speed_i     = speed;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy_o;
    end
  endtask

  task automatic push_event(input logic ev_type, input logic [2:0] dev_id, input logic [2:0] code,
                            input logic [15:0] steps, input logic [15:0] abs_steps,
                            input logic signed [15:0] position, input logic [15:0] speed);
    send_beat(iecq_pkg::FuncPush, ev_type, dev_id, code, steps, abs_steps, position, speed);
  endtask

  task automatic pop_event();
    send_beat(iecq_pkg::FuncPop, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
              3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  // Hold off until every result is in, then let the pipeline settle
  task automatic wait_drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Pick a push that often continues the last event so merges get exercised
  task automatic random_push();
    int             mode;
    logic           ev_type;
    logic [2:0]     dev_id;
    logic [2:0]     code;
    logic [15:0]    abs_steps;
    mode = $urandom_range(0, 9);
    if (mode <= 2) begin
      ev_type = 1'($urandom_range(0, 1));
      dev_id  = 3'($urandom_range(0, 7));
      code    = 3'($urandom_range(0, 7));
    end else if (mode <= 5) begin
      ev_type = last_type;
      dev_id  = last_id;
      code    = last_code;
    end else begin
      ev_type = iecq_pkg::EvButton;
      dev_id  = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : last_id;
      code    = (mode <= 7) ? iecq_pkg::CodeClick : iecq_pkg::CodeDouble;
    end
    abs_steps = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
    last_type = ev_type;
    last_id   = dev_id;
    last_code = code;
    push_event(ev_type, dev_id, code, 16'($urandom), abs_steps, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int push_pct[6];
    push_pct = '{85, 50, 15, 95, 30, 60};
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty pop, merges with wrap, mismatched merges, full queue
    pop_event();
    push_event(iecq_pkg::EvEncoder, 3'd7, 3'd2, 16'hFFFF, 16'hFFFF, 16'sh8000, 16'hFFFF);
    push_event(iecq_pkg::EvEncoder, 3'd7, 3'd2, 16'h0000, 16'h0001, 16'sh7FFF, 16'h0000);
    push_event(iecq_pkg::EvEncoder, 3'd7, 3'd1, 16'h1234, 16'h0000, 16'sh0000, 16'h8000);
    push_event(iecq_pkg::EvButton, 3'd4, iecq_pkg::CodeClick, 16'h0000, 16'h0000, 16'sh0000,
               16'h0000);
    push_event(iecq_pkg::EvButton, 3'd3, iecq_pkg::CodeDouble, 16'hFFFF, 16'hFFFF, 16'shFFFF,
               16'hFFFF);
    push_event(iecq_pkg::EvButton, 3'd3, iecq_pkg::CodeClick, 16'h00FF, 16'hFF00, 16'sh0F0F,
               16'hF0F0);
    push_event(iecq_pkg::EvButton, 3'd3, iecq_pkg::CodeDouble, 16'h5555, 16'hAAAA, 16'sh5555,
               16'hAAAA);
    push_event(iecq_pkg::EvButton, 3'd3, iecq_pkg::CodeDouble, 16'h0001, 16'h0002, 16'sh0003,
               16'h0004);
    push_event(iecq_pkg::EvEncoder, 3'd0, 3'd0, 16'h0000, 16'h0000, 16'sh7FFF, 16'h0000);
    push_event(iecq_pkg::EvButton, 3'd0, iecq_pkg::CodeDouble, 16'h0000, 16'h0000, 16'sh0000,
               16'h0000);
    for (int i = 0; i < 8; i++) begin
      push_event(iecq_pkg::EvButton, 3'(i), iecq_pkg::CodeClick, 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
    end
    push_event(iecq_pkg::EvEncoder, 3'd5, 3'd2, 16'h0001, 16'h0001, 16'sh0001, 16'h0001);
    push_event(iecq_pkg::EvButton, 3'd7, iecq_pkg::CodeDouble, 16'h0000, 16'h0000, 16'sh0000,
               16'h0000);
    push_event(iecq_pkg::EvButton, 3'd7, iecq_pkg::CodeDouble, 16'h0000, 16'h0000, 16'sh0000,
               16'h0000);
    repeat (17) pop_event();
    wait_drain();

    // Random phases with different push/pop mix so the queue runs full and empty
    for (int p = 0; p < 6; p++) begin
      repeat (150) begin
        if ($urandom_range(1, 100) <= push_pct[p]) random_push();
        else pop_event();
      end
      wait_drain();
    end

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: input_event_queue_coalesce.f
design/iecq_pkg.sv
design/iecq_ram.sv
design/iecq_merge.sv
design/input_event_queue_coalesce.sv
test/testbench.sv
